### design/fsc_pkg.sv
// Shared types, constants and round function for the Feistel S-box cipher block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package fsc_pkg;

  // Cipher geometry
  localparam int HALF_W          = 16;
  localparam int KEY_BANK_W      = 64;
  localparam int ROUND_COUNT_DEF = 9;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = KEY_BANK_W;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEYS_1_TO_4 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEYS_5_TO_8 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_9       = 2'd2;

  // Queue between round pipeline and accumulator
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // 4-bit S-box
  localparam logic [3:0] SBOX [16] = '{
    4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
    4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // Destination of permutation input i, where input i is bit 15-i of the S-box word
  localparam logic [3:0] PERM_DEST [16] = '{
    4'd4, 4'd13, 4'd9, 4'd3, 4'd7, 4'd8, 4'd2, 4'd15,
    4'd12, 4'd1, 4'd6, 4'd11, 4'd0, 4'd14, 4'd10, 4'd5
  };

  // Item moving through the pipeline and the queue
  typedef struct packed {
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
    logic              first;
    logic              last;
  } fsc_item_t;

  // Queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } fsc_queue_status_t;

  // Round function: S-box layer followed by bit permutation
  function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] x);
    logic [HALF_W-1:0] w;
    logic [HALF_W-1:0] z;
    for (int i = 0; i < 4; i++) begin
      w[4*i +: 4] = SBOX[x[4*i +: 4]];
    end
    z = '0;
    for (int i = 0; i < HALF_W; i++) begin
      z[PERM_DEST[i]] = w[HALF_W-1-i];
    end
    return z;
  endfunction

  // Select the subkey of a round (rounds counted from one)
  function automatic logic [HALF_W-1:0] subkey_of(
    input int unsigned             rnd,
    input logic [KEY_BANK_W-1:0]   keys_1_to_4,
    input logic [KEY_BANK_W-1:0]   keys_5_to_8,
    input logic [HALF_W-1:0]       key_9
  );
    logic [HALF_W-1:0] k;
    if (rnd >= 1 && rnd <= 4) begin
      k = keys_1_to_4[HALF_W*(rnd-1) +: HALF_W];
    end else if (rnd >= 5 && rnd <= 8) begin
      k = keys_5_to_8[HALF_W*(rnd-5) +: HALF_W];
    end else begin
      k = key_9;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### design/fsc_round_pipe.sv
// Front part: accepts plaintexts and runs one Feistel round per pipeline stage.
// Depends on fsc_pkg; pushes finished ciphertexts into fsc_queue.
`default_nettype none

module fsc_round_pipe #(
  parameter int ROUND_COUNT = fsc_pkg::ROUND_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire fsc_pkg::fsc_item_t              in_item,
  input  wire logic [fsc_pkg::KEY_BANK_W-1:0]  keys_1_to_4,
  input  wire logic [fsc_pkg::KEY_BANK_W-1:0]  keys_5_to_8,
  input  wire logic [fsc_pkg::HALF_W-1:0]      key_9,
  input  wire fsc_pkg::fsc_queue_status_t      q_status,
  output logic                                 q_push,
  output fsc_pkg::fsc_item_t                   q_item
);

  fsc_pkg::fsc_item_t st_r   [ROUND_COUNT];
  logic               vld_r  [ROUND_COUNT];
  fsc_pkg::fsc_item_t st_in  [ROUND_COUNT];
  fsc_pkg::fsc_item_t st_nxt [ROUND_COUNT];
  logic               adv;

  // Advance the whole pipeline unless the last stage is blocked by a full queue
  assign adv      = !(vld_r[ROUND_COUNT-1] && q_status.full);
  assign in_stall = !adv;
  assign q_push   = vld_r[ROUND_COUNT-1] && !q_status.full;
  assign q_item   = st_r[ROUND_COUNT-1];

  // One Feistel round per stage
  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    logic [fsc_pkg::HALF_W-1:0] key;
    logic [fsc_pkg::HALF_W-1:0] f;

    if (g == 0) begin : g_head
      assign st_in[g] = in_item;
    end else begin : g_body
      assign st_in[g] = st_r[g-1];
    end

    assign key = fsc_pkg::subkey_of(g + 1, keys_1_to_4, keys_5_to_8, key_9);
    assign f   = fsc_pkg::round_fn(st_in[g].right ^ key);

    always_comb begin
      st_nxt[g]       = st_in[g];
      st_nxt[g].left  = st_in[g].right;
      st_nxt[g].right = st_in[g].left ^ f;
    end
  end

  // Hold valid flags; clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROUND_COUNT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < ROUND_COUNT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ROUND_COUNT; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

### design/fsc_queue.sv
// Short queue that decouples the round pipeline from the accumulator stage.
// Depends on fsc_pkg for the item type and depth.
`default_nettype none

module fsc_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire fsc_pkg::fsc_item_t         push_item,
  input  wire logic                       pop,
  output fsc_pkg::fsc_item_t              pop_item,
  output fsc_pkg::fsc_queue_status_t      status
);

  fsc_pkg::fsc_item_t                  mem_r [fsc_pkg::QUEUE_DEPTH];
  logic [fsc_pkg::QUEUE_PTR_W-1:0]     wr_ptr_r;
  logic [fsc_pkg::QUEUE_PTR_W-1:0]     rd_ptr_r;
  logic [fsc_pkg::QUEUE_CNT_W-1:0]     cnt_r;
  logic [fsc_pkg::QUEUE_CNT_W-1:0]     cnt_nxt;

  assign status.full  = (cnt_r == fsc_pkg::QUEUE_CNT_W'(fsc_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### design/fsc_accum.sv
// Back part: folds ciphertexts into the running XOR sums and sticky ORs,
// and holds the result register. Depends on fsc_pkg.
`default_nettype none

module fsc_accum (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fsc_pkg::fsc_queue_status_t  q_status,
  input  wire fsc_pkg::fsc_item_t          q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [fsc_pkg::HALF_W-1:0]       out_cipher_left,
  output logic [fsc_pkg::HALF_W-1:0]       out_cipher_right,
  output logic [fsc_pkg::HALF_W-1:0]       out_xor_sum_left_out,
  output logic [fsc_pkg::HALF_W-1:0]       out_xor_sum_right_out,
  output logic [fsc_pkg::HALF_W-1:0]       out_sticky_left_out,
  output logic [fsc_pkg::HALF_W-1:0]       out_sticky_right_out
);

  logic                        out_valid_r;
  logic [fsc_pkg::HALF_W-1:0]  xsum_l_r, xsum_r_r, stk_l_r, stk_r_r;
  logic [fsc_pkg::HALF_W-1:0]  xsum_l_nxt, xsum_r_nxt, stk_l_nxt, stk_r_nxt;
  logic [fsc_pkg::HALF_W-1:0]  cl_r, cr_r;

  // Take the next item when the result register is free or being drained
  assign q_pop = !q_status.empty && (!out_valid_r || !out_stall);

  // Clear sums on first of set, fold this item in, OR into sticky on last of set
  always_comb begin
    xsum_l_nxt = (q_item.first ? '0 : xsum_l_r) ^ q_item.left;
    xsum_r_nxt = (q_item.first ? '0 : xsum_r_r) ^ q_item.right;
    stk_l_nxt  = q_item.last ? (stk_l_r | xsum_l_nxt) : stk_l_r;
    stk_r_nxt  = q_item.last ? (stk_r_r | xsum_r_nxt) : stk_r_r;
  end

  // Hold accumulators and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      xsum_l_r    <= '0;
      xsum_r_r    <= '0;
      stk_l_r     <= '0;
      stk_r_r     <= '0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        xsum_l_r    <= xsum_l_nxt;
        xsum_r_r    <= xsum_r_nxt;
        stk_l_r     <= stk_l_nxt;
        stk_r_r     <= stk_r_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load ciphertext into the result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cl_r <= q_item.left;
      cr_r <= q_item.right;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_cipher_left       = cl_r;
  assign out_cipher_right      = cr_r;
  assign out_xor_sum_left_out  = xsum_l_r;
  assign out_xor_sum_right_out = xsum_r_r;
  assign out_sticky_left_out   = stk_l_r;
  assign out_sticky_right_out  = stk_r_r;

endmodule

`default_nettype wire

### design/feistel_sbox_cipher_integral_sum.sv
// Top level: Feistel S-box cipher with integral XOR-sum check.
// Holds the round-key registers; instantiates fsc_round_pipe, fsc_queue, fsc_accum.
//
// Usage:
//   Input channel (in_valid / in_stall): one plaintext as two 16-bit halves plus
//   first/last-of-set flags; a transfer happens when in_valid is high and
//   in_stall is low.
//   Result channel (out_valid / out_stall): ciphertext halves, the running XOR
//   sums including this item and the sticky ORs over completed sets.
//   Configuration: cfg_wr_en writes cfg_wdata to the key register chosen by
//   cfg_index (0: rounds 1-4, 1: rounds 5-8, 2: round 9); write only while idle.
// Path from input transfer to out_valid: the transferring edge loads the first round
// stage, each further round has its own stage, then the item passes through the queue
// and the result register.
// Throughput: one item per cycle while in_stall is low; each round has its own stage.
// Reset (rst_n low, synchronous) clears keys, sums, sticky accumulators and all
// valid flags.
// When the receiver stalls, the result register holds, the four-entry queue
// fills, then the round pipeline freezes and in_stall rises.
`default_nettype none

module feistel_sbox_cipher_integral_sum #(
  parameter int ROUND_COUNT = fsc_pkg::ROUND_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [fsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [fsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [fsc_pkg::HALF_W-1:0]        in_plain_left,
  input  wire logic [fsc_pkg::HALF_W-1:0]        in_plain_right,
  input  wire logic                              in_first_of_set,
  input  wire logic                              in_last_of_set,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [fsc_pkg::HALF_W-1:0]             out_cipher_left,
  output logic [fsc_pkg::HALF_W-1:0]             out_cipher_right,
  output logic [fsc_pkg::HALF_W-1:0]             out_xor_sum_left_out,
  output logic [fsc_pkg::HALF_W-1:0]             out_xor_sum_right_out,
  output logic [fsc_pkg::HALF_W-1:0]             out_sticky_left_out,
  output logic [fsc_pkg::HALF_W-1:0]             out_sticky_right_out
);

  logic [fsc_pkg::KEY_BANK_W-1:0]  keys_1_to_4_r;
  logic [fsc_pkg::KEY_BANK_W-1:0]  keys_5_to_8_r;
  logic [fsc_pkg::HALF_W-1:0]      key_9_r;

  fsc_pkg::fsc_item_t              in_item;
  fsc_pkg::fsc_item_t              push_item;
  fsc_pkg::fsc_item_t              pop_item;
  fsc_pkg::fsc_queue_status_t      q_status;
  logic                            q_push;
  logic                            q_pop;

  // Write key registers; other indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_1_to_4_r <= '0;
      keys_5_to_8_r <= '0;
      key_9_r       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fsc_pkg::CFG_KEYS_1_TO_4: keys_1_to_4_r <= cfg_wdata;
        fsc_pkg::CFG_KEYS_5_TO_8: keys_5_to_8_r <= cfg_wdata;
        fsc_pkg::CFG_KEY_9:       key_9_r       <= cfg_wdata[fsc_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Pack the input fields
  always_comb begin
    in_item.left  = in_plain_left;
    in_item.right = in_plain_right;
    in_item.first = in_first_of_set;
    in_item.last  = in_last_of_set;
  end

  fsc_round_pipe #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_round_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .keys_1_to_4 (keys_1_to_4_r),
    .keys_5_to_8 (keys_5_to_8_r),
    .key_9       (key_9_r),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  fsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  fsc_accum u_accum (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_status              (q_status),
    .q_item                (pop_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_cipher_left       (out_cipher_left),
    .out_cipher_right      (out_cipher_right),
    .out_xor_sum_left_out  (out_xor_sum_left_out),
    .out_xor_sum_right_out (out_xor_sum_right_out),
    .out_sticky_left_out   (out_sticky_left_out),
    .out_sticky_right_out  (out_sticky_right_out)
  );

endmodule

`default_nettype wire

### test/feistel_sbox_cipher_integral_sum_test.sv
// Self-checking testbench for feistel_sbox_cipher_integral_sum: directed plaintexts,
// integral sets and random traffic under random idling, checked by a local cipher model.
// Depends on fsc_pkg and the block's RTL only.
`default_nettype none

module feistel_sbox_cipher_integral_sum_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUNDS          = fsc_pkg::ROUND_COUNT_DEF;
  localparam int IDLE_PCT        = 38;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int RANDOM_PHASES   = 5;
  localparam int CALM_FROM       = 350;
  localparam int CALM_TO         = 520;
  localparam int QUIET_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 2 * (ROUNDS + 2);

  typedef logic [fsc_pkg::CFG_INDEX_W-1:0] slot_t;
  typedef logic [fsc_pkg::HALF_W-1:0]      half_t;
  // index beyond the last key register: writes there must be ignored
  localparam slot_t CFG_SPARE_SLOT = slot_t'(3);

  // S-box, nibble i at bits 4i+3..4i
  localparam logic [63:0] NIBBLE_SUB = 64'h2174_8fe3_da09_b65c;
  // destination of permutation input i (bit 15-i of the S-box word), nibble i
  localparam logic [63:0] BIT_DEST   = 64'h5ae0_b61c_f287_39d4;

  typedef struct packed {
    half_t cipher_l;
    half_t cipher_r;
    half_t sum_l;
    half_t sum_r;
    half_t sticky_l;
    half_t sticky_r;
  } cipher_record_t;

  typedef struct packed {
    half_t pl;
    half_t pr;
    logic  first;
    logic  last;
    logic  sums_cancel;   // running sums known to come back as zero
  } plain_row_t;

  // Directed plaintexts; pairs of equal plaintexts inside one set cancel in the sums
  localparam int DIRECTED_ROWS = 13;
  localparam plain_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0},
    '{16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1},
    '{16'hffff, 16'hffff, 1'b1, 1'b1, 1'b0},
    '{16'h0000, 16'hffff, 1'b1, 1'b0, 1'b0},
    '{16'hffff, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h0000, 16'hffff, 1'b0, 1'b0, 1'b0},
    '{16'hffff, 16'h0000, 1'b0, 1'b1, 1'b1},
    '{16'haaaa, 16'h5555, 1'b0, 1'b0, 1'b0},
    '{16'h5555, 16'haaaa, 1'b0, 1'b1, 1'b0},
    '{16'h8000, 16'h0001, 1'b1, 1'b1, 1'b0},
    '{16'h0001, 16'h8000, 1'b1, 1'b0, 1'b0},
    '{16'h1234, 16'hcdef, 1'b0, 1'b0, 1'b0},
    '{16'hfedc, 16'hba98, 1'b1, 1'b1, 1'b0}
  };

  logic                           clk;
  logic                           rst_n           = 1'b0;
  logic                           cfg_wr_en       = 1'b0;
  slot_t                          cfg_index       = '0;
  logic [fsc_pkg::CFG_DATA_W-1:0] cfg_wdata       = '0;
  logic                           in_valid        = 1'b0;
  logic                           in_stall;
  half_t                          in_plain_left   = '0;
  half_t                          in_plain_right  = '0;
  logic                           in_first_of_set = 1'b0;
  logic                           in_last_of_set  = 1'b0;
  logic                           out_valid;
  logic                           out_stall       = 1'b0;
  half_t                          out_cipher_left;
  half_t                          out_cipher_right;
  half_t                          out_xor_sum_left_out;
  half_t                          out_xor_sum_right_out;
  half_t                          out_sticky_left_out;
  half_t                          out_sticky_right_out;

  // Model state: key registers, running sums, sticky accumulators
  logic [fsc_pkg::KEY_BANK_W-1:0] key_bank_lo;
  logic [fsc_pkg::KEY_BANK_W-1:0] key_bank_hi;
  half_t                          key_nine;
  half_t                          run_sum_l;
  half_t                          run_sum_r;
  half_t                          seen_l;
  half_t                          seen_r;

  cipher_record_t ciphertexts_due [$];
  int  fault_count    = 0;
  int  sent_count     = 0;
  int  checked_count  = 0;
  int  sets_closed    = 0;
  int  integral_sets  = 0;
  int  key_settings   = 1;
  bit  calm           = 1'b0;

  feistel_sbox_cipher_integral_sum #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_plain_left         (in_plain_left),
    .in_plain_right        (in_plain_right),
    .in_first_of_set       (in_first_of_set),
    .in_last_of_set        (in_last_of_set),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_cipher_left       (out_cipher_left),
    .out_cipher_right      (out_cipher_right),
    .out_xor_sum_left_out  (out_xor_sum_left_out),
    .out_xor_sum_right_out (out_xor_sum_right_out),
    .out_sticky_left_out   (out_sticky_left_out),
    .out_sticky_right_out  (out_sticky_right_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // S-box layer on every nibble, then scatter the bits
  function automatic half_t scramble_half(input half_t x);
    half_t      subst;
    half_t      moved;
    logic [3:0] dest;
    for (int n = 0; n < 4; n++) begin
      subst[4*n +: 4] = NIBBLE_SUB[4*x[4*n +: 4] +: 4];
    end
    moved = '0;
    for (int b = 0; b < fsc_pkg::HALF_W; b++) begin
      dest = BIT_DEST[4*b +: 4];
      moved[dest] = subst[fsc_pkg::HALF_W-1-b];
    end
    return moved;
  endfunction

  // Subkey of round k, rounds counted from one
  function automatic half_t round_subkey(input int k);
    if (k >= 1 && k <= 4) begin
      return key_bank_lo[fsc_pkg::HALF_W*(k-1) +: fsc_pkg::HALF_W];
    end else if (k >= 5 && k <= 8) begin
      return key_bank_hi[fsc_pkg::HALF_W*(k-5) +: fsc_pkg::HALF_W];
    end
    return key_nine;
  endfunction

  // Encrypt one plaintext and advance the sums and sticky accumulators
  function automatic cipher_record_t encipher_and_accumulate(
    input half_t pl,
    input half_t pr,
    input logic  first,
    input logic  last
  );
    cipher_record_t rec;
    half_t          l;
    half_t          r;
    half_t          nxt;
    l = pl;
    r = pr;
    for (int k = 1; k <= ROUNDS; k++) begin
      nxt = l ^ scramble_half(r ^ round_subkey(k));
      l   = r;
      r   = nxt;
    end
    if (first) begin
      run_sum_l = '0;
      run_sum_r = '0;
    end
    run_sum_l = run_sum_l ^ l;
    run_sum_r = run_sum_r ^ r;
    if (last) begin
      seen_l = seen_l | run_sum_l;
      seen_r = seen_r | run_sum_r;
      sets_closed++;
    end
    rec = '{l, r, run_sum_l, run_sum_r, seen_l, seen_r};
    return rec;
  endfunction

  // Write the key registers picked by the mask; the spare slot gets all ones
  task automatic load_keys(
    input logic [3:0]                     pick,
    input logic [fsc_pkg::KEY_BANK_W-1:0] lo,
    input logic [fsc_pkg::KEY_BANK_W-1:0] hi,
    input logic [fsc_pkg::KEY_BANK_W-1:0] nine
  );
    slot_t                          slot;
    logic [fsc_pkg::CFG_DATA_W-1:0] word;
    for (int idx = 0; idx < 4; idx++) begin
      if (pick[idx]) begin
        slot = slot_t'(idx);
        case (slot)
          fsc_pkg::CFG_KEYS_1_TO_4: begin
            word = lo;
            key_bank_lo = word;
          end
          fsc_pkg::CFG_KEYS_5_TO_8: begin
            word = hi;
            key_bank_hi = word;
          end
          fsc_pkg::CFG_KEY_9: begin
            word = nine;
            key_nine = word[fsc_pkg::HALF_W-1:0];
          end
          default: begin
            word = '1;
          end
        endcase
        cfg_wr_en <= 1'b1;
        cfg_index <= slot;
        cfg_wdata <= word;
        @(posedge clk);
      end
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Present one plaintext, wait for its transfer, queue its expected result
  task automatic send_plaintext(
    input half_t pl,
    input half_t pr,
    input logic  first,
    input logic  last,
    input logic  sums_cancel
  );
    cipher_record_t rec;
    calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < IDLE_PCT);
    end
    in_valid        <= 1'b1;
    in_plain_left   <= pl;
    in_plain_right  <= pr;
    in_first_of_set <= first;
    in_last_of_set  <= last;
    do @(posedge clk); while (in_stall);
    rec = encipher_and_accumulate(pl, pr, first, last);
    if (sums_cancel) begin
      rec.sum_l = '0;
      rec.sum_r = '0;
    end
    ciphertexts_due.push_back(rec);
    sent_count++;
  endtask

  // Drop valid and wait until every queued ciphertext has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ciphertexts_due.size() != 0) @(posedge clk);
  endtask

  // Mostly integral sets over one nibble and random well-formed sets, some loose items
  task automatic run_random_phase(input int count);
    int    done_n;
    int    kind;
    int    size;
    int    pos;
    half_t base_l;
    half_t base_r;
    half_t l;
    half_t r;
    done_n = 0;
    while (done_n < count) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        base_l = half_t'($urandom);
        base_r = half_t'($urandom);
        pos    = $urandom_range(7);
        for (int v = 0; v < 16; v++) begin
          l = base_l;
          r = base_r;
          if (pos < 4) begin
            l[4*pos +: 4] = v[3:0];
          end else begin
            r[4*(pos-4) +: 4] = v[3:0];
          end
          send_plaintext(l, r, v == 0, v == 15, 1'b0);
        end
        done_n += 16;
        integral_sets++;
      end else if (kind < 80) begin
        size = $urandom_range(8, 1);
        for (int i = 0; i < size; i++) begin
          send_plaintext(half_t'($urandom), half_t'($urandom), i == 0, i == size - 1,
                         1'b0);
        end
        done_n += size;
      end else begin
        send_plaintext(half_t'($urandom), half_t'($urandom), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'b0);
        done_n++;
      end
    end
  endtask

  // Compare one field of a result
  task automatic compare_field(
    input string what,
    input half_t want_v,
    input half_t got_v
  );
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
      fault_count++;
    end
  endtask

  // Receiver stalls at random, except in the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    cipher_record_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (ciphertexts_due.size() == 0) begin
        $display("%0t ns: result with none expected, cipher %h_%h", $time,
                 out_cipher_left, out_cipher_right);
        fault_count++;
      end else begin
        want = ciphertexts_due.pop_front();
        compare_field("cipher_left",  want.cipher_l, out_cipher_left);
        compare_field("cipher_right", want.cipher_r, out_cipher_right);
        compare_field("xor_sum_left",  want.sum_l, out_xor_sum_left_out);
        compare_field("xor_sum_right", want.sum_r, out_xor_sum_right_out);
        compare_field("sticky_left",  want.sticky_l, out_sticky_left_out);
        compare_field("sticky_right", want.sticky_r, out_sticky_right_out);
        checked_count++;
      end
    end
  end

  // End the run if no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t ns: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    key_bank_lo = '0;
    key_bank_hi = '0;
    key_nine    = '0;
    run_sum_l   = '0;
    run_sum_r   = '0;
    seen_l      = '0;
    seen_r      = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset keys; a write to the spare slot must leave them alone
    load_keys(4'b1000, '0, '0, '0);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_plaintext(DIRECTED[i].pl, DIRECTED[i].pr, DIRECTED[i].first,
                     DIRECTED[i].last, DIRECTED[i].sums_cancel);
    end
    drain_results();

    // Random phases: all ones, random keys, then all zeros
    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      if (ph == 1) begin
        load_keys(4'b0111, '1, '1, '1);
      end else if (ph == RANDOM_PHASES) begin
        load_keys(4'b0111, '0, '0, '0);
      end else begin
        load_keys(4'b1111, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom});
      end
      key_settings++;
      run_random_phase(ITEMS_PER_PHASE);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ciphertexts_due.size() != 0) begin
      $display("%0d expected ciphertexts never arrived", ciphertexts_due.size());
      fault_count += ciphertexts_due.size();
    end

    $display("Sent %0d plaintexts under %0d key settings, checked %0d results.",
             sent_count, key_settings, checked_count);
    $display("Closed %0d sets, %0d of them integral over one nibble.",
             sets_closed, integral_sets);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
